@@ rtl/core/uyvy_to_bgr_converter_macros.svh @@
// Assertion macros shared by the UYVY to BGR converter RTL.
// Define ASSERT_OFF to compile every assertion away; no other dependencies.
`ifndef UYVY_TO_BGR_CONVERTER_MACROS_SVH
`define UYVY_TO_BGR_CONVERTER_MACROS_SVH

`ifndef ASSERT_OFF
// Checks a property at each rising clock edge outside reset.
`define U2B_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("u2b assertion failed");
// Checks that an expression is never true outside reset.
`define U2B_ASSERT_NEVER(label, clk, rst, expr) \
   `U2B_ASSERT(label, clk, rst, !(expr))
`else
`define U2B_ASSERT(label, clk, rst, prop)
`define U2B_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

@@ rtl/core/u2b_pkg.sv @@
// Package for the UYVY to BGR converter: widths, Q14 coefficients and shared types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package u2b_pkg;

   localparam int SAMPLE_W  = 8;
   localparam int COEF_W    = 17;
   localparam int PROD_W    = 25;
   localparam int FRAC_BITS = 14;
   localparam int OFS_W     = PROD_W - FRAC_BITS;
   localparam int SUM_W     = 12;

   localparam logic [SAMPLE_W-1:0] CHROMA_BIAS = 8'd128;

   localparam logic signed [COEF_W-1:0] COEF_U_BLUE  = 17'sd33292;
   localparam logic signed [COEF_W-1:0] COEF_V_GREEN = -17'sd9519;
   localparam logic signed [COEF_W-1:0] COEF_U_GREEN = 17'sd6472;
   localparam logic signed [COEF_W-1:0] COEF_V_RED   = 17'sd18678;
   localparam logic signed [PROD_W-1:0] ROUND_TERM   = 25'sd8192;

   // Chroma offsets shared by both pixels of a macropixel.
   typedef struct packed {
      logic signed [OFS_W-1:0] blue;
      logic signed [OFS_W-1:0] green;
      logic signed [OFS_W-1:0] red;
   } chroma_ofs_type;

   // One output pixel.
   typedef struct packed {
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] blue;
   } pixel_type;

   // Load enables of the pipeline stages.
   typedef struct packed {
      logic s1_load;
      logic s2_load;
   } pipe_ctrl_type;

endpackage

@@ rtl/core/u2b_chroma.sv @@
// Shared chroma unit: removes the chroma bias, forms the Q14 products and
// rounds them to the three color offsets. Depends on u2b_pkg.
`timescale 1ns / 1ps

module u2b_chroma (
   input  logic                          clock,
   input  u2b_pkg::pipe_ctrl_type        ctrl,
   input  logic [u2b_pkg::SAMPLE_W-1:0]  cb_sample,
   input  logic [u2b_pkg::SAMPLE_W-1:0]  cr_sample,
   output u2b_pkg::chroma_ofs_type       offsets
);
   import u2b_pkg::*;

   logic signed [SAMPLE_W-1:0] u_s;
   logic signed [SAMPLE_W-1:0] v_s;
   logic signed [PROD_W-1:0]   u_wide;
   logic signed [PROD_W-1:0]   v_wide;

   logic signed [PROD_W-1:0] prod_ub_in, prod_ub_ff;
   logic signed [PROD_W-1:0] prod_vg_in, prod_vg_ff;
   logic signed [PROD_W-1:0] prod_ug_in, prod_ug_ff;
   logic signed [PROD_W-1:0] prod_vr_in, prod_vr_ff;

   logic signed [PROD_W-1:0] green_sum;
   logic signed [PROD_W-1:0] blue_rnd;
   logic signed [PROD_W-1:0] green_rnd;
   logic signed [PROD_W-1:0] red_rnd;
   chroma_ofs_type           ofs_in, ofs_ff;

   // Subtracting the bias in eight bits leaves the signed chroma value.
   always_comb begin
      u_s    = $signed(cb_sample - CHROMA_BIAS);
      v_s    = $signed(cr_sample - CHROMA_BIAS);
      u_wide = PROD_W'(u_s);
      v_wide = PROD_W'(v_s);
      prod_ub_in = u_wide * PROD_W'(COEF_U_BLUE);
      prod_vg_in = v_wide * PROD_W'(COEF_V_GREEN);
      prod_ug_in = u_wide * PROD_W'(COEF_U_GREEN);
      prod_vr_in = v_wide * PROD_W'(COEF_V_RED);
   end

   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         prod_ub_ff <= prod_ub_in;
         prod_vg_ff <= prod_vg_in;
         prod_ug_ff <= prod_ug_in;
         prod_vr_ff <= prod_vr_in;
      end
   end

   // Taking the upper bits of the rounded value is a floor shift by FRAC_BITS.
   always_comb begin
      green_sum    = prod_vg_ff - prod_ug_ff;
      blue_rnd     = prod_ub_ff + ROUND_TERM;
      green_rnd    = green_sum + ROUND_TERM;
      red_rnd      = prod_vr_ff + ROUND_TERM;
      ofs_in.blue  = $signed(blue_rnd[PROD_W-1:FRAC_BITS]);
      ofs_in.green = $signed(green_rnd[PROD_W-1:FRAC_BITS]);
      ofs_in.red   = $signed(red_rnd[PROD_W-1:FRAC_BITS]);
   end

   always_ff @(posedge clock) begin
      if (ctrl.s2_load) begin
         ofs_ff <= ofs_in;
      end
   end

   assign offsets = ofs_ff;

endmodule

@@ rtl/core/u2b_lane.sv @@
// One pixel lane: adds the shared chroma offsets to a luma byte and clamps
// each sum to a byte. Depends on u2b_pkg.
`timescale 1ns / 1ps

module u2b_lane (
   input  logic [u2b_pkg::SAMPLE_W-1:0] luma,
   input  u2b_pkg::chroma_ofs_type      offsets,
   output u2b_pkg::pixel_type           pixel
);
   import u2b_pkg::*;

   function automatic logic [SAMPLE_W-1:0] clamp_sum(
      input logic [SAMPLE_W-1:0] y,
      input logic signed [OFS_W-1:0] ofs
   );
      logic signed [SUM_W-1:0] sum;
      sum = $signed(SUM_W'(y)) + SUM_W'(ofs);
      if (sum[SUM_W-1]) begin
         clamp_sum = '0;
      end else if (sum[SUM_W-2:SAMPLE_W] != '0) begin
         clamp_sum = '1;
      end else begin
         clamp_sum = sum[SAMPLE_W-1:0];
      end
   endfunction

   always_comb begin
      pixel.blue  = clamp_sum(luma, offsets.blue);
      pixel.green = clamp_sum(luma, offsets.green);
      pixel.red   = clamp_sum(luma, offsets.red);
   end

endmodule

@@ rtl/core/uyvy_to_bgr_converter.sv @@
// Top level of the UYVY to BGR converter: stream handshake, pipeline control,
// two pixel lanes and the merging output register. Uses u2b_pkg, u2b_chroma, u2b_lane.
`timescale 1ns / 1ps
`include "uyvy_to_bgr_converter_macros.svh"

// Usage:
// The req_ channel carries one UYVY macropixel per transaction: the U byte,
// the first luma, the V byte and the second luma. The rsp_ channel returns one
// transaction per macropixel holding two BGR pixels that share its chroma.
// There is no configuration port and no state between macropixels.
//
// On its way to rsp_tvalid an accepted request passes the chroma product stage,
// the stage rounding the products into offsets, and the output register that
// merges the results of the two pixel lanes.
// Throughput is one macropixel per clock while the receiver accepts; each stage
// reloads whenever the stage after it is empty or moving, so a full pipeline streams without gaps.
//
// When the receiver stalls, the output register holds its transaction and
// stable data; the stages behind it keep filling until every stage is
// occupied, and only then does req_tready fall. Synchronous reset empties
// all three stages; data registers are not cleared.
module uyvy_to_bgr_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] cb_sample, [15:8] luma_first, [23:16] cr_sample, [31:24] luma_second
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] blue_first, [15:8] green_first, [23:16] red_first,
   // [31:24] blue_second, [39:32] green_second, [47:40] red_second
   output logic [47:0] rsp_tdata
);
   import u2b_pkg::*;

   logic [SAMPLE_W-1:0] cb_sample;
   logic [SAMPLE_W-1:0] luma_first;
   logic [SAMPLE_W-1:0] cr_sample;
   logic [SAMPLE_W-1:0] luma_second;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_load;
   pipe_ctrl_type ctrl;

   logic [2*SAMPLE_W-1:0] s1_luma_ff;
   logic [2*SAMPLE_W-1:0] s2_luma_ff;
   chroma_ofs_type        offsets;
   pixel_type             pixel_first;
   pixel_type             pixel_second;
   logic [47:0]           out_data_in, out_data_ff;

   assign cb_sample   = req_tdata[7:0];
   assign luma_first  = req_tdata[15:8];
   assign cr_sample   = req_tdata[23:16];
   assign luma_second = req_tdata[31:24];

   // A stage loads when it is empty or when its contents move on this cycle.
   always_comb begin
      out_load     = !out_valid_ff || rsp_tready;
      ctrl.s2_load = !s2_valid_ff || out_load;
      ctrl.s1_load = !s1_valid_ff || ctrl.s2_load;
      req_tready   = ctrl.s1_load;
      s1_valid_in  = ctrl.s1_load ? req_tvalid : s1_valid_ff;
      s2_valid_in  = ctrl.s2_load ? s1_valid_ff : s2_valid_ff;
      out_valid_in = out_load ? s2_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // The luma bytes travel beside the chroma unit until the lanes need them.
   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         s1_luma_ff <= {luma_second, luma_first};
      end
      if (ctrl.s2_load) begin
         s2_luma_ff <= s1_luma_ff;
      end
   end

   u2b_chroma u_chroma (
      .clock     (clock),
      .ctrl      (ctrl),
      .cb_sample (cb_sample),
      .cr_sample (cr_sample),
      .offsets   (offsets)
   );

   u2b_lane u_lane_first (
      .luma    (s2_luma_ff[SAMPLE_W-1:0]),
      .offsets (offsets),
      .pixel   (pixel_first)
   );

   u2b_lane u_lane_second (
      .luma    (s2_luma_ff[2*SAMPLE_W-1:SAMPLE_W]),
      .offsets (offsets),
      .pixel   (pixel_second)
   );

   // Merge the two lanes into one BGR pair, blue of the first pixel lowest.
   assign out_data_in = {pixel_second.red, pixel_second.green, pixel_second.blue,
                         pixel_first.red, pixel_first.green, pixel_first.blue};

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // With an empty output register nothing can hold back the input.
   `U2B_ASSERT(a_ready_when_out_empty, clock, reset, !out_valid_ff |-> req_tready)
   // An accepted transaction always occupies the first stage.
   `U2B_ASSERT(a_accept_fills_s1, clock, reset,
      (req_tvalid && req_tready) |=> s1_valid_ff)
   // A blocked first stage keeps its transaction and its luma bytes.
   `U2B_ASSERT(a_s1_holds, clock, reset,
      (s1_valid_ff && !ctrl.s2_load) |=> (s1_valid_ff && $stable(s1_luma_ff)))
   // A finished offset stage moves into a free output register.
   `U2B_ASSERT(a_s2_drains, clock, reset, (s2_valid_ff && out_load) |=> rsp_tvalid)
   // A full pipeline with a stalled receiver refuses new input.
   `U2B_ASSERT_NEVER(a_no_overrun, clock, reset,
      s1_valid_ff && s2_valid_ff && out_valid_ff && !rsp_tready && req_tready)

endmodule
